// ===== sv/gtb_pkg.sv =====
// Shared types, coefficient and brightness tables for the Goertzel tone detector.
package gtb_pkg;

   localparam int MAX_BINS  = 16;
   localparam int TABLE_W   = 4;
   localparam int STATE_W   = 40;
   localparam int COEF_W    = 16;
   localparam int SHIFT_W   = 4;
   localparam int FRAC_BITS = 14;
   localparam int OPER_W    = 31;
   localparam int PROD_W    = COEF_W + STATE_W;
   localparam int FB_W      = PROD_W - FRAC_BITS;
   localparam int SUM_W     = FB_W + 2;
   localparam int CB_W      = COEF_W + OPER_W;
   localparam int TAP_W     = CB_W - FRAC_BITS;
   localparam int SQ_W      = 2 * OPER_W;
   localparam int POWER_W   = 64;
   localparam int BRIGHT_W  = 8;
   localparam int BIN_OUT_W = 3;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic [BRIGHT_W-1:0] bright_type;

   localparam coef_type COEF_TABLE [MAX_BINS] = '{
      16'sd31651, 16'sd28378, 16'sd23170, 16'sd16384,
      16'sd8481,  16'sd0,     -16'sd8481, -16'sd16384,
      -16'sd23170, -16'sd28378, -16'sd31651, 16'sh8000,
      -16'sd31651, -16'sd28378, -16'sd23170, -16'sd16384
   };

   localparam bright_type BRIGHT_TABLE [MAX_BINS] = '{
      8'd0,   8'd15,  8'd70,  8'd122, 8'd175, 8'd229, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
   };

   typedef struct packed {
      logic sample_load;
      logic upd_issue;
      logic shift_inc;
      logic pw_issue;
      logic load_out;
      logic clear;
   } dp_cmd_type;

   typedef struct packed {
      logic fits;
      logic pw_busy;
   } dp_status_type;

endpackage

// ===== sv/gtb_ctrl.sv =====
// Controller state machine that sequences resonator updates, scaling scan and power compare.
module gtb_ctrl
   import gtb_pkg::*;
#(
   parameter int SAMPLES_PER_CHUNK = 24,
   parameter int BIN_COUNT         = 6,
   parameter int IDX_W             = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   output logic [IDX_W-1:0] bin_idx,
   input  dp_status_type status
);

   localparam int CNT_W = $clog2(SAMPLES_PER_CHUNK);
   localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(BIN_COUNT - 1);
   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(SAMPLES_PER_CHUNK - 1);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_UPDATE   = 6'b000010,
      ST_UPD_WAIT = 6'b000100,
      ST_SHIFT    = 6'b001000,
      ST_POWER    = 6'b010000,
      ST_DRAIN    = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] bin_ff, bin_in;
   logic [CNT_W-1:0] chunk_ff, chunk_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             last_bin;

   assign last_bin  = (bin_ff == LAST_BIN);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign bin_idx   = bin_ff;

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      chunk_in     = chunk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.sample_load = 1'b1;
               bin_in          = '0;
               state_in        = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.upd_issue = 1'b1;
            if (last_bin) begin
               state_in = ST_UPD_WAIT;
            end else begin
               bin_in = bin_ff + 1'b1;
            end
         end
         ST_UPD_WAIT: begin
            bin_in = '0;
            if (chunk_ff == LAST_POS) begin
               chunk_in = '0;
               state_in = ST_SHIFT;
            end else begin
               chunk_in = chunk_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            if (status.fits) begin
               if (last_bin) begin
                  bin_in   = '0;
                  state_in = ST_POWER;
               end else begin
                  bin_in = bin_ff + 1'b1;
               end
            end else begin
               cmd.shift_inc = 1'b1;
            end
         end
         ST_POWER: begin
            cmd.pw_issue = 1'b1;
            if (last_bin) begin
               state_in = ST_DRAIN;
            end else begin
               bin_in = bin_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pw_busy && !(rsp_valid_ff && !rsp_ready)) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               bin_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bin_ff       <= '0;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bin_ff       <= bin_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/gtb_dp.sv =====
// Datapath with resonator state, shared update multiplier, scaling check and power pipeline.
module gtb_dp
   import gtb_pkg::*;
#(
   parameter int BIN_COUNT    = 6,
   parameter int SAMPLE_WIDTH = 16,
   parameter int IDX_W        = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [SAMPLE_WIDTH-1:0] req_sample,
   input  dp_cmd_type              cmd,
   input  logic [IDX_W-1:0]        bin_idx,
   output dp_status_type           status,
   output logic [BRIGHT_W-1:0]     rsp_brightness,
   output logic [BIN_OUT_W-1:0]    rsp_winning_bin
);

   typedef logic signed [STATE_W-1:0] state_val_type;
   typedef logic signed [OPER_W-1:0]  oper_type;

   state_val_type q1_ff [BIN_COUNT];
   state_val_type q2_ff [BIN_COUNT];
   state_val_type sample_ff;
   logic [SHIFT_W-1:0] shift_ff;

   logic                      upd_v_ff;
   logic [IDX_W-1:0]          upd_idx_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   state_val_type             upd_q1_ff;
   state_val_type             upd_q2_ff;

   logic                      p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff;
   logic [IDX_W-1:0]          p1_idx_ff, p2_idx_ff, p3_idx_ff, p4_idx_ff;
   oper_type                  p1_a_ff, p1_b_ff, p2_a_ff, p2_b_ff, p3_a_ff;
   coef_type                  p1_c_ff;
   logic signed [CB_W-1:0]    cb_ff;
   logic signed [SQ_W-1:0]    aa_ff, bb_ff;
   logic signed [TAP_W-1:0]   t_ff;
   logic signed [POWER_W-1:0] at_ff, sq_ff;
   logic signed [POWER_W-1:0] best_ff;
   logic [IDX_W-1:0]          best_idx_ff;

   logic [BRIGHT_W-1:0]       bright_ff;
   logic [BIN_OUT_W-1:0]      win_ff;

   state_val_type             rd_q1, rd_q2, sh_q1, sh_q2, sat_val;
   coef_type                  coef_sel;
   logic signed [PROD_W-1:0]  prod_round;
   logic signed [FB_W-1:0]    fb;
   logic signed [SUM_W-1:0]   upd_sum;
   logic signed [CB_W-1:0]    cb_round;
   logic signed [POWER_W-1:0] power;

   function automatic logic fits30(input state_val_type v);
      logic [STATE_W-OPER_W:0] top;
      top = v[STATE_W-1:OPER_W-1];
      fits30 = (top == '0) || ((top == '1) && (v[OPER_W-2:0] != '0));
   endfunction

   assign rd_q1    = q1_ff[bin_idx];
   assign rd_q2    = q2_ff[bin_idx];
   assign coef_sel = COEF_TABLE[TABLE_W'(bin_idx)];
   assign sh_q1    = rd_q1 >>> shift_ff;
   assign sh_q2    = rd_q2 >>> shift_ff;

   assign prod_round = prod_ff + $signed(PROD_W'(1) << (FRAC_BITS - 1));
   assign fb         = FB_W'(prod_round >>> FRAC_BITS);
   assign upd_sum    = SUM_W'(fb) - SUM_W'(upd_q2_ff) + SUM_W'(sample_ff);

   always_comb begin
      if (upd_sum[SUM_W-1:STATE_W-1] == '0 || upd_sum[SUM_W-1:STATE_W-1] == '1) begin
         sat_val = upd_sum[STATE_W-1:0];
      end else if (upd_sum[SUM_W-1]) begin
         sat_val = {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(STATE_W-1){1'b1}}};
      end
   end

   assign cb_round = cb_ff + $signed(CB_W'(1) << (FRAC_BITS - 1));
   assign power    = sq_ff - at_ff;

   assign status.fits    = fits30(sh_q1) && fits30(sh_q2);
   assign status.pw_busy = p1_v_ff || p2_v_ff || p3_v_ff || p4_v_ff;

   assign rsp_brightness  = bright_ff;
   assign rsp_winning_bin = win_ff;

   // Resonator history and scaling shift.
   always_ff @(posedge clock) begin
      for (int i = 0; i < BIN_COUNT; i++) begin
         if (reset || cmd.clear) begin
            q1_ff[i] <= '0;
            q2_ff[i] <= '0;
         end else if (upd_v_ff && (upd_idx_ff == IDX_W'(i))) begin
            q1_ff[i] <= sat_val;
            q2_ff[i] <= upd_q1_ff;
         end
      end
      if (reset || cmd.clear) begin
         shift_ff <= '0;
      end else if (cmd.shift_inc) begin
         shift_ff <= shift_ff + 1'b1;
      end
   end

   // Control bits of the update and power pipelines.
   always_ff @(posedge clock) begin
      if (reset) begin
         upd_v_ff <= 1'b0;
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         p3_v_ff  <= 1'b0;
         p4_v_ff  <= 1'b0;
      end else begin
         upd_v_ff <= cmd.upd_issue;
         p1_v_ff  <= cmd.pw_issue;
         p2_v_ff  <= p1_v_ff;
         p3_v_ff  <= p2_v_ff;
         p4_v_ff  <= p3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         best_ff     <= '0;
         best_idx_ff <= '0;
      end else if (p4_v_ff && (power > best_ff)) begin
         best_ff     <= power;
         best_idx_ff <= p4_idx_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.sample_load) begin
         sample_ff <= STATE_W'(signed'(req_sample));
      end
      if (cmd.upd_issue) begin
         prod_ff    <= coef_sel * rd_q1;
         upd_idx_ff <= bin_idx;
         upd_q1_ff  <= rd_q1;
         upd_q2_ff  <= rd_q2;
      end
      p1_a_ff   <= sh_q1[OPER_W-1:0];
      p1_b_ff   <= sh_q2[OPER_W-1:0];
      p1_c_ff   <= coef_sel;
      p1_idx_ff <= bin_idx;
      cb_ff     <= p1_c_ff * p1_b_ff;
      p2_a_ff   <= p1_a_ff;
      p2_b_ff   <= p1_b_ff;
      p2_idx_ff <= p1_idx_ff;
      aa_ff     <= p2_a_ff * p2_a_ff;
      bb_ff     <= p2_b_ff * p2_b_ff;
      t_ff      <= TAP_W'(cb_round >>> FRAC_BITS);
      p3_a_ff   <= p2_a_ff;
      p3_idx_ff <= p2_idx_ff;
      at_ff     <= p3_a_ff * t_ff;
      sq_ff     <= POWER_W'(aa_ff) + POWER_W'(bb_ff);
      p4_idx_ff <= p3_idx_ff;
      if (cmd.load_out) begin
         bright_ff <= BRIGHT_TABLE[TABLE_W'(best_idx_ff)];
         win_ff    <= BIN_OUT_W'(5'(best_idx_ff) + 5'd1);
      end
   end

endmodule

// ===== sv/goertzel_tone_to_brightness.sv =====
// Each sample passes its bins one bin per cycle through the shared update multiplier.
// After the last sample of a chunk the scaling scan runs and then the power pipeline, and the
// result word is valid once the power pipeline is empty, later while an older word waits.
// The next sample is taken once the result word is loaded and the resonators are cleared.
// Synchronous reset clears the resonators, the chunk counter, the scan state and rsp_valid.
module goertzel_tone_to_brightness
   import gtb_pkg::*;
#(
   parameter int SAMPLES_PER_CHUNK = 24,
   parameter int BIN_COUNT         = 6,
   parameter int SAMPLE_WIDTH      = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SAMPLE_WIDTH-1:0] req_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [BRIGHT_W-1:0]     rsp_brightness,
   output logic [BIN_OUT_W-1:0]    rsp_winning_bin
);

   localparam int IDX_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

   dp_cmd_type       cmd;
   dp_status_type    status;
   logic [IDX_W-1:0] bin_idx;

   gtb_ctrl #(
      .SAMPLES_PER_CHUNK(SAMPLES_PER_CHUNK),
      .BIN_COUNT        (BIN_COUNT),
      .IDX_W            (IDX_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .bin_idx  (bin_idx),
      .status   (status)
   );

   gtb_dp #(
      .BIN_COUNT   (BIN_COUNT),
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .IDX_W       (IDX_W)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_sample     (req_sample),
      .cmd            (cmd),
      .bin_idx        (bin_idx),
      .status         (status),
      .rsp_brightness (rsp_brightness),
      .rsp_winning_bin(rsp_winning_bin)
   );

endmodule

// ===== sv/gtb_checker.sv =====
// Port-level checker for the Goertzel tone detector and its bind to the top level.
module gtb_checker
   import gtb_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [BRIGHT_W-1:0]  rsp_brightness,
   input logic [BIN_OUT_W-1:0] rsp_winning_bin
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid is set after reset");

   a_one_word_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("a second word was offered ready right after an accepted word");

   a_result_not_immediate: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("a result word appeared right after an accepted word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_brightness) && $stable(rsp_winning_bin)))
      else $error("a stalled result word changed or dropped");

endmodule

bind goertzel_tone_to_brightness gtb_checker u_checker (.*);

// ===== tb/tb_goertzel_tone_to_brightness.sv =====
// Testbench for the Goertzel tone detector: tone, noise and silence chunks with a built-in predictor.
`timescale 1ns / 100ps

module tb_goertzel_tone_to_brightness
   import gtb_pkg::*;
();

   localparam int CHUNK_LEN      = 24;
   localparam int BINS           = 6;
   localparam int SAMPLE_W       = 16;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 60;
   localparam real PI            = 3.14159265358979;
   localparam longint STATE_MAX  = (longint'(1) <<< (STATE_W - 1)) - 1;
   localparam longint STATE_MIN  = -(longint'(1) <<< (STATE_W - 1));
   localparam longint POWER_LIM  = longint'(1) <<< 30;

   typedef struct packed {
      logic [BRIGHT_W-1:0]  brightness;
      logic [BIN_OUT_W-1:0] winning_bin;
   } tone_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [SAMPLE_W-1:0]  req_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   logic [BRIGHT_W-1:0]  rsp_brightness;
   logic [BIN_OUT_W-1:0] rsp_winning_bin;

   bit            idle_en = 1'b1;
   int            stall_left = 0;
   int            mismatch_count = 0;
   int            idle_cycles = 0;
   int            chunk_pos = 0;
   longint        res_last [BINS];
   longint        res_prev [BINS];
   tone_word_type expected_tones [$];

   goertzel_tone_to_brightness #(
      .SAMPLES_PER_CHUNK(CHUNK_LEN),
      .BIN_COUNT(BINS),
      .SAMPLE_WIDTH(SAMPLE_W)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_brightness(rsp_brightness),
      .rsp_winning_bin(rsp_winning_bin)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit fits_power(input longint v, input int sh);
      longint a;
      a = v >>> sh;
      return (a < POWER_LIM) && (a > -POWER_LIM);
   endfunction

   task automatic clear_resonators();
      chunk_pos = 0;
      for (int k = 0; k < BINS; k++) begin
         res_last[k] = 0;
         res_prev[k] = 0;
      end
   endtask

   // Advances every resonator by one sample and, at the end of a chunk, queues the winning tone.
   task automatic goertzel_step(input logic [SAMPLE_W-1:0] raw);
      longint        x;
      longint        fb;
      longint        q0;
      longint        a;
      longint        b;
      longint        t;
      longint        p;
      longint        best_power;
      int            best_bin;
      int            shift;
      bit            ok;
      tone_word_type word;
      x = longint'($signed(raw));
      for (int k = 0; k < BINS; k++) begin
         fb = (longint'(COEF_TABLE[k]) * res_last[k] + 8192) >>> FRAC_BITS;
         q0 = fb - res_prev[k] + x;
         if (q0 > STATE_MAX) q0 = STATE_MAX;
         if (q0 < STATE_MIN) q0 = STATE_MIN;
         res_prev[k] = res_last[k];
         res_last[k] = q0;
      end
      chunk_pos++;
      if (chunk_pos == CHUNK_LEN) begin
         shift = 0;
         ok = 1'b0;
         while (!ok && shift < 16) begin
            ok = 1'b1;
            for (int k = 0; k < BINS; k++) begin
               if (!fits_power(res_last[k], shift) || !fits_power(res_prev[k], shift)) ok = 1'b0;
            end
            if (!ok) shift++;
         end
         best_power = 0;
         best_bin = 1;
         for (int k = 0; k < BINS; k++) begin
            a = res_last[k] >>> shift;
            b = res_prev[k] >>> shift;
            t = (longint'(COEF_TABLE[k]) * b + 8192) >>> FRAC_BITS;
            p = a * a + b * b - a * t;
            if (p > best_power) begin
               best_power = p;
               best_bin = k + 1;
            end
         end
         word.brightness  = BRIGHT_TABLE[(best_bin - 1) % MAX_BINS];
         word.winning_bin = best_bin[BIN_OUT_W-1:0];
         expected_tones.push_back(word);
         clear_resonators();
      end
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int gap;
      if (idle_en && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      goertzel_step(s);
   endtask

   function automatic logic [SAMPLE_W-1:0] tone_sample(input int bin, input int n, input real amp,
                                                        input real phase, input int noise,
                                                        input bit square);
      real c;
      int  v;
      c = $cos(2.0 * PI * bin * n / CHUNK_LEN + phase);
      if (square) begin
         v = (c >= 0.0) ? 32767 : -32768;
      end else begin
         v = $rtoi(amp * c) + int'($urandom_range(0, 2 * noise)) - noise;
      end
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic send_tone_chunk(input int bin, input bit square, input int noise);
      real amp;
      real phase;
      amp = $urandom_range(100, 32767);
      phase = $urandom_range(0, 6283) / 1000.0;
      for (int n = 0; n < CHUNK_LEN; n++) begin
         send_sample(tone_sample(bin, n, amp, phase, noise, square));
      end
   endtask

   task automatic send_noise_chunk(input int noise);
      for (int n = 0; n < CHUNK_LEN; n++) begin
         if (noise == 0) send_sample(SAMPLE_W'($urandom));
         else send_sample(SAMPLE_W'(int'($urandom_range(0, 2 * noise)) - noise));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_tones.size() != 0);
   endtask

   task automatic test_silence();
      for (int n = 0; n < CHUNK_LEN; n++) send_sample('0);
   endtask

   task automatic test_pure_tones();
      for (int i = 0; i < 12; i++) begin
         send_tone_chunk((i < BINS) ? i + 1 : $urandom_range(0, 11), 1'b0, $urandom_range(0, 3000));
      end
   endtask

   task automatic test_square_tones();
      for (int i = 0; i < 4; i++) send_tone_chunk($urandom_range(0, 12), 1'b1, 0);
   endtask

   task automatic test_noise();
      for (int i = 0; i < 5; i++) send_noise_chunk((i % 2 == 0) ? 0 : $urandom_range(1, 60));
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 4; i++) begin
         send_tone_chunk($urandom_range(1, BINS), 1'b0, 500);
         wait_drained();
      end
   endtask

   task automatic test_no_idle();
      idle_en = 1'b0;
      for (int i = 0; i < 6; i++) begin
         if (i % 3 == 2) send_noise_chunk(0);
         else send_tone_chunk($urandom_range(1, BINS), 1'b0, $urandom_range(0, 2000));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 8) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      tone_word_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (expected_tones.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result word: brightness %0d bin %0d",
                           rsp_brightness, rsp_winning_bin);
               end
            end else begin
               want = expected_tones.pop_front();
               if (rsp_brightness !== want.brightness || rsp_winning_bin !== want.winning_bin) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: brightness exp %0d got %0d, bin exp %0d got %0d",
                              want.brightness, rsp_brightness, want.winning_bin, rsp_winning_bin);
                  end
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      clear_resonators();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_silence();
      test_pure_tones();
      test_square_tones();
      test_noise();
      test_drain_pause();
      test_no_idle();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
